// ===== sv/settable_digital_clock_assert.svh =====
// Assertion macros shared by the clock RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef SETTABLE_DIGITAL_CLOCK_ASSERT_SVH
`define SETTABLE_DIGITAL_CLOCK_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define SDC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

`define SDC_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define SDC_ASSERT(label, clk, rst_n, prop)

`define SDC_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// ===== sv/sdc_pkg.sv =====
package sdc_pkg;

    localparam int unsigned TickWidth   = 16;
    localparam int unsigned HourWidth   = 5;
    localparam int unsigned MinWidth    = 6;
    localparam int unsigned SecWidth    = 6;
    localparam int unsigned SegWidth    = 8;
    localparam int unsigned CfgIdxWidth = 2;
    localparam int unsigned CfgWidth    = 16;

    localparam logic [HourWidth-1:0] HourMax     = 5'd23;
    localparam logic [MinWidth-1:0]  MinSecMax   = 6'd59;
    localparam logic [SecWidth-1:0]  ChimeFirst  = 6'd50;
    localparam logic [SecWidth-1:0]  ChimeLast   = 6'd58;
    localparam logic [SecWidth-1:0]  SecWrap     = 6'd60;

    localparam logic [TickWidth-1:0] TpsReset    = 16'd100;
    localparam logic [HourWidth-1:0] ChimeHourReset = 5'd23;
    localparam logic [MinWidth-1:0]  ChimeMinReset  = 6'd59;

    localparam logic [SegWidth-1:0] SEG_BLANK = 8'h00;
    localparam logic [SegWidth-1:0] SEG_DASH  = 8'h40;
    localparam logic [SegWidth-1:0] SEG_DP    = 8'h80;

    typedef enum logic [1:0] {
        OP_TICK      = 2'd0,
        OP_SET_ENTER = 2'd1,
        OP_ADJUST    = 2'd2,
        OP_SET_LEAVE = 2'd3
    } t_op;

    localparam logic [1:0] UNIT_HOURS   = 2'd0;
    localparam logic [1:0] UNIT_MINUTES = 2'd1;
    localparam logic [1:0] UNIT_SECONDS = 2'd2;

    localparam logic [1:0] STEP_PLUS_ONE  = 2'd0;
    localparam logic [1:0] STEP_MINUS_ONE = 2'd1;
    localparam logic [1:0] STEP_PLUS_TEN  = 2'd2;
    localparam logic [1:0] STEP_MINUS_TEN = 2'd3;

    localparam logic [CfgIdxWidth-1:0] CFG_TICKS_PER_SECOND = 2'd0;
    localparam logic [CfgIdxWidth-1:0] CFG_CHIME_HOUR       = 2'd1;
    localparam logic [CfgIdxWidth-1:0] CFG_CHIME_MINUTE     = 2'd2;

    typedef struct packed {
        logic [2:0] tens;
        logic [3:0] ones;
    } t_digits;

    typedef struct packed {
        logic [HourWidth-1:0] hours;
        logic [MinWidth-1:0]  minutes;
        logic [SecWidth-1:0]  seconds;
        logic                 chime;
        logic                 set_mode;
        logic [SegWidth-1:0]  prefix_segments;
        logic [SegWidth-1:0]  hour_tens_segments;
        logic [SegWidth-1:0]  hour_ones_segments;
        logic [SegWidth-1:0]  minute_tens_segments;
        logic [SegWidth-1:0]  minute_ones_segments;
        logic [SegWidth-1:0]  second_tens_segments;
        logic [SegWidth-1:0]  second_ones_segments;
    } t_result;

    // Common-cathode pattern, segment a in bit 0.
    function automatic logic [SegWidth-1:0] seg_digit(input logic [3:0] digit);
        logic [SegWidth-1:0] seg;
        case (digit)
            4'd0:    seg = 8'h3f;
            4'd1:    seg = 8'h06;
            4'd2:    seg = 8'h5b;
            4'd3:    seg = 8'h4f;
            4'd4:    seg = 8'h66;
            4'd5:    seg = 8'h6d;
            4'd6:    seg = 8'h7d;
            4'd7:    seg = 8'h07;
            4'd8:    seg = 8'h7f;
            4'd9:    seg = 8'h6f;
            default: seg = SEG_BLANK;
        endcase
        return seg;
    endfunction

    // Values stay below 64, so a ladder of compares replaces the divide.
    function automatic t_digits split_digits(input logic [5:0] value);
        t_digits    d;
        logic [5:0] base;
        if (value >= 6'd60) begin
            d.tens = 3'd6; base = 6'd60;
        end else if (value >= 6'd50) begin
            d.tens = 3'd5; base = 6'd50;
        end else if (value >= 6'd40) begin
            d.tens = 3'd4; base = 6'd40;
        end else if (value >= 6'd30) begin
            d.tens = 3'd3; base = 6'd30;
        end else if (value >= 6'd20) begin
            d.tens = 3'd2; base = 6'd20;
        end else if (value >= 6'd10) begin
            d.tens = 3'd1; base = 6'd10;
        end else begin
            d.tens = 3'd0; base = 6'd0;
        end
        d.ones = 4'(value - base);
        return d;
    endfunction

    // Step a unit with no carry; overflow goes to 0, underflow to the maximum.
    function automatic logic [5:0] adjust_value(input logic [5:0] value,
                                                input logic [5:0] max_value,
                                                input logic [1:0] step);
        logic signed [7:0] r;
        logic [5:0]        res;
        r = $signed({2'b00, value});
        unique case (step)
            STEP_PLUS_ONE:  r = r + 8'sd1;
            STEP_MINUS_ONE: r = r - 8'sd1;
            STEP_PLUS_TEN:  r = r + 8'sd10;
            default:        r = r - 8'sd10;
        endcase
        if (r > $signed({2'b00, max_value})) begin
            res = '0;
        end else if (r < 8'sd0) begin
            res = max_value;
        end else begin
            res = r[5:0];
        end
        return res;
    endfunction

endpackage

// ===== sv/settable_digital_clock.sv =====
// 24-hour clock with set mode and seven-segment digit codes. Every accepted
// transaction (tick, enter set mode, adjust, leave set mode) yields one
// registered result; one transaction is taken per cycle while o_stall is low.
// The time counters and the result are computed in a single pass from the
// current state, so back-to-back transactions need no gaps. A one-entry skid
// stage sits behind the result register: o_stall rises only when both hold
// results the sink has not yet taken. Write configuration only while idle.
`include "settable_digital_clock_assert.svh"

module settable_digital_clock import sdc_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   i_cfg_we,
    input  logic [CfgIdxWidth-1:0] i_cfg_index,
    input  logic [CfgWidth-1:0]    i_cfg_data,

    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [1:0]             i_operation,
    input  logic [1:0]             i_adjust_unit,
    input  logic [1:0]             i_adjust_step,

    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [HourWidth-1:0]   o_hours,
    output logic [MinWidth-1:0]    o_minutes,
    output logic [SecWidth-1:0]    o_seconds,
    output logic                   o_chime,
    output logic                   o_set_mode,
    output logic [SegWidth-1:0]    o_prefix_segments,
    output logic [SegWidth-1:0]    o_hour_tens_segments,
    output logic [SegWidth-1:0]    o_hour_ones_segments,
    output logic [SegWidth-1:0]    o_minute_tens_segments,
    output logic [SegWidth-1:0]    o_minute_ones_segments,
    output logic [SegWidth-1:0]    o_second_tens_segments,
    output logic [SegWidth-1:0]    o_second_ones_segments
);

    logic [TickWidth-1:0] r_tps;
    logic [HourWidth-1:0] r_chime_hour;
    logic [MinWidth-1:0]  r_chime_min;

    logic [TickWidth-1:0] r_tick_count, n_tick_count;
    logic [HourWidth-1:0] r_hour, n_hour;
    logic [MinWidth-1:0]  r_min, n_min;
    logic [SecWidth-1:0]  r_sec, n_sec;
    logic                 r_setting, n_setting;
    logic                 n_chime;

    t_result r_out, r_skid, n_result;
    logic    r_out_valid, r_skid_valid;

    t_op                  w_op;
    logic                 w_in_accept;
    logic                 w_out_take;
    logic [TickWidth:0]   w_tick_next;
    logic [SecWidth-1:0]  w_sec_inc;
    logic [MinWidth-1:0]  w_min_inc;
    logic [HourWidth-1:0] w_hour_inc;
    logic [5:0]           w_adj;
    t_digits              w_hour_dig, w_min_dig, w_sec_dig;

    assign w_op        = t_op'(i_operation);
    assign w_in_accept = i_valid && !r_skid_valid;
    assign w_out_take  = r_out_valid && !i_stall;

    assign w_tick_next = {1'b0, r_tick_count} + 17'd1;
    assign w_sec_inc   = r_sec + 6'd1;
    assign w_min_inc   = r_min + 6'd1;
    assign w_hour_inc  = r_hour + 5'd1;

    always_comb begin
        n_tick_count = r_tick_count;
        n_hour       = r_hour;
        n_min        = r_min;
        n_sec        = r_sec;
        n_setting    = r_setting;
        n_chime      = 1'b0;
        w_adj        = '0;
        unique case (w_op)
            OP_TICK: begin
                if (!r_setting) begin
                    // a zero or lowered tick rate still advances on this tick
                    if (w_tick_next >= {1'b0, r_tps}) begin
                        n_tick_count = '0;
                        n_sec        = w_sec_inc;
                        n_chime      = (r_hour == r_chime_hour) && (r_min == r_chime_min) &&
                                       (w_sec_inc >= ChimeFirst) && (w_sec_inc <= ChimeLast) &&
                                       !w_sec_inc[0];
                        if (w_sec_inc >= SecWrap) begin
                            n_sec = '0;
                            n_min = w_min_inc;
                            if (r_min == MinSecMax) begin
                                n_min  = '0;
                                n_hour = (r_hour == HourMax) ? '0 : w_hour_inc;
                            end
                        end
                    end else begin
                        n_tick_count = w_tick_next[TickWidth-1:0];
                    end
                end
            end
            OP_SET_ENTER: n_setting = 1'b1;
            OP_ADJUST: begin
                if (r_setting) begin
                    unique case (i_adjust_unit)
                        UNIT_HOURS: begin
                            w_adj  = adjust_value({1'b0, r_hour}, {1'b0, HourMax},
                                                  i_adjust_step);
                            n_hour = w_adj[HourWidth-1:0];
                        end
                        UNIT_MINUTES: begin
                            w_adj = adjust_value(r_min, MinSecMax, i_adjust_step);
                            n_min = w_adj;
                        end
                        UNIT_SECONDS: begin
                            w_adj = adjust_value(r_sec, MinSecMax, i_adjust_step);
                            n_sec = w_adj;
                        end
                        default: ;  // no such unit: drop
                    endcase
                end
            end
            OP_SET_LEAVE: n_setting = 1'b0;
        endcase
    end

    assign w_hour_dig = split_digits({1'b0, n_hour});
    assign w_min_dig  = split_digits(n_min);
    assign w_sec_dig  = split_digits(n_sec);

    always_comb begin
        n_result.hours                = n_hour;
        n_result.minutes              = n_min;
        n_result.seconds              = n_sec;
        n_result.chime                = n_chime;
        n_result.set_mode             = n_setting;
        n_result.prefix_segments      = n_setting ? SEG_DASH : SEG_BLANK;
        n_result.hour_tens_segments   = seg_digit({1'b0, w_hour_dig.tens});
        n_result.hour_ones_segments   = seg_digit(w_hour_dig.ones) | SEG_DP;
        n_result.minute_tens_segments = seg_digit({1'b0, w_min_dig.tens});
        n_result.minute_ones_segments = seg_digit(w_min_dig.ones) | SEG_DP;
        n_result.second_tens_segments = seg_digit({1'b0, w_sec_dig.tens});
        n_result.second_ones_segments = seg_digit(w_sec_dig.ones);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps        <= TpsReset;
            r_chime_hour <= ChimeHourReset;
            r_chime_min  <= ChimeMinReset;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TICKS_PER_SECOND: r_tps        <= i_cfg_data;
                CFG_CHIME_HOUR:       r_chime_hour <= i_cfg_data[HourWidth-1:0];
                CFG_CHIME_MINUTE:     r_chime_min  <= i_cfg_data[MinWidth-1:0];
                default: ;  // unknown register: drop the write
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_count <= '0;
            r_hour       <= '0;
            r_min        <= '0;
            r_sec        <= '0;
            r_setting    <= 1'b0;
        end else if (w_in_accept) begin
            r_tick_count <= n_tick_count;
            r_hour       <= n_hour;
            r_min        <= n_min;
            r_sec        <= n_sec;
            r_setting    <= n_setting;
        end
    end

    // Output register plus skid: a new result goes to the skid entry only
    // when the output register is full and not being taken this cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_in_accept) begin
            if (!r_out_valid || w_out_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_out_take) begin
            r_out_valid  <= r_skid_valid;
            r_skid_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            if (!r_out_valid || w_out_take) begin
                r_out <= n_result;
            end else begin
                r_skid <= n_result;
            end
        end else if (w_out_take && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

    assign o_stall                = r_skid_valid;
    assign o_valid                = r_out_valid;
    assign o_hours                = r_out.hours;
    assign o_minutes              = r_out.minutes;
    assign o_seconds              = r_out.seconds;
    assign o_chime                = r_out.chime;
    assign o_set_mode             = r_out.set_mode;
    assign o_prefix_segments      = r_out.prefix_segments;
    assign o_hour_tens_segments   = r_out.hour_tens_segments;
    assign o_hour_ones_segments   = r_out.hour_ones_segments;
    assign o_minute_tens_segments = r_out.minute_tens_segments;
    assign o_minute_ones_segments = r_out.minute_ones_segments;
    assign o_second_tens_segments = r_out.second_tens_segments;
    assign o_second_ones_segments = r_out.second_ones_segments;

    `SDC_ASSERT_NEVER(a_skid_without_out, i_clk, i_rst_n, r_skid_valid && !r_out_valid)

    `SDC_ASSERT(a_time_in_range, i_clk, i_rst_n,
        (r_hour <= HourMax) && (r_min <= MinSecMax) && (r_sec <= MinSecMax))

    `SDC_ASSERT(a_chime_second, i_clk, i_rst_n,
        (r_out_valid && r_out.chime) |->
        ((r_out.seconds >= ChimeFirst) && (r_out.seconds <= ChimeLast) &&
         !r_out.seconds[0] && !r_out.set_mode))

    `SDC_ASSERT(a_mode_change_keeps_time, i_clk, i_rst_n,
        (w_in_accept && (w_op == OP_SET_ENTER || w_op == OP_SET_LEAVE)) |=>
        ($stable(r_hour) && $stable(r_min) && $stable(r_sec) && $stable(r_tick_count)))

endmodule
